/* design/sflot_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sflot_pkg
// Shared types and constants for the six-frame longest ORF tracker.
// ----------------------------------------------------------------------------
package sflot_pkg;

    localparam int POS_W   = 24;  // nucleotide coordinate width
    localparam int LEN_W   = 24;  // codon count width
    localparam int TO_W    = 26;  // end coordinate width
    localparam int FRAME_W = 2;
    localparam int IDX_W   = 3;
    localparam int NPLUS   = 3;
    localparam int NFRAMES = 2 * NPLUS;

    localparam logic [LEN_W-1:0]   LEN_MAX    = {LEN_W{1'b1}};
    localparam logic [TO_W-1:0]    TO_MAX     = {TO_W{1'b1}};
    localparam logic [FRAME_W-1:0] FRAME_NONE = 2'd3;

    typedef logic [POS_W-1:0] t_pos;
    typedef logic [LEN_W-1:0] t_len;
    typedef t_len [NFRAMES-1:0] t_len_vec;
    typedef t_pos [NFRAMES-1:0] t_pos_vec;

    typedef struct packed {
        logic [POS_W-1:0]   position;
        logic [FRAME_W-1:0] frame;
        logic               strand_minus;
        logic               atg_start;
        logic               alt_start;
        logic               orf_stop;
        logic               last_of_sequence;
    } t_in_word;

    typedef struct packed {
        logic [IDX_W-1:0] best_frame;
        logic [LEN_W-1:0] best_length;
        logic [POS_W-1:0] orf_from;
        logic [TO_W-1:0]  orf_to;
        logic             orf_on_minus;
    } t_out_word;

    function automatic t_len sat_inc(input t_len v);
        sat_inc = (v == LEN_MAX) ? LEN_MAX : v + t_len'(1);
    endfunction

endpackage
`default_nettype wire

/* design/sflot_result.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sflot_result
// Picks the frame with the longest ORF from a snapshot of per-frame bests
// and forms the result word: snapshot, selection and output register stages.
// ----------------------------------------------------------------------------
module sflot_result (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_snap_valid,
    output logic                   o_snap_ready,
    input  sflot_pkg::t_len_vec    i_best_len,
    input  sflot_pkg::t_pos_vec    i_best_start,
    output logic                   o_out_valid,
    input  wire                    i_out_ready,
    output sflot_pkg::t_out_word   o_out_word
);
    import sflot_pkg::*;

    localparam int SUM_W = TO_W + 1;

    // snapshot stage
    logic     r_snap_valid;
    t_len_vec r_snap_len;
    t_pos_vec r_snap_start;
    // selection stage
    logic             r_sel_valid;
    logic [IDX_W-1:0] r_sel_idx;
    t_len             r_sel_len;
    t_pos             r_sel_start;
    // output stage
    logic      r_out_valid;
    t_out_word r_out_word;

    logic out_ready, sel_ready, snap_ready;
    logic [IDX_W-1:0] w01, w23, w45, w0123, n_sel_idx;
    logic [FRAME_W-1:0] offset;
    t_pos       from_pos;
    logic [SUM_W-1:0] to_sum;
    t_out_word  n_out_word;

    assign out_ready    = !r_out_valid || i_out_ready;
    assign sel_ready    = !r_sel_valid || out_ready;
    assign snap_ready   = !r_snap_valid || sel_ready;
    assign o_snap_ready = snap_ready;

    // pairwise tree, a later frame wins only when strictly longer
    always_comb begin
        w01 = (r_snap_len[1] > r_snap_len[0]) ? IDX_W'(1) : IDX_W'(0);
        w23 = (r_snap_len[3] > r_snap_len[2]) ? IDX_W'(3) : IDX_W'(2);
        w45 = (r_snap_len[5] > r_snap_len[4]) ? IDX_W'(5) : IDX_W'(4);
        w0123     = (r_snap_len[w23] > r_snap_len[w01]) ? w23 : w01;
        n_sel_idx = (r_snap_len[w45] > r_snap_len[w0123]) ? w45 : w0123;
    end

    always_comb begin
        if (r_sel_idx >= IDX_W'(NPLUS)) begin
            offset = FRAME_W'(r_sel_idx - IDX_W'(NPLUS));
        end else begin
            offset = FRAME_W'(r_sel_idx);
        end
        from_pos = r_sel_start + POS_W'(offset);
        to_sum   = SUM_W'(from_pos) + SUM_W'({r_sel_len, 1'b0}) + SUM_W'(r_sel_len)
                 + SUM_W'(2);
        n_out_word.best_frame   = r_sel_idx;
        n_out_word.best_length  = r_sel_len;
        n_out_word.orf_from     = from_pos;
        n_out_word.orf_to       = (to_sum > SUM_W'(TO_MAX)) ? TO_MAX : TO_W'(to_sum);
        n_out_word.orf_on_minus = (r_sel_idx >= IDX_W'(NPLUS));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
            r_sel_valid  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (snap_ready) begin
                r_snap_valid <= i_snap_valid;
            end
            if (sel_ready) begin
                r_sel_valid <= r_snap_valid;
            end
            if (out_ready) begin
                r_out_valid <= r_sel_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (snap_ready && i_snap_valid) begin
            r_snap_len   <= i_best_len;
            r_snap_start <= i_best_start;
        end
        if (sel_ready && r_snap_valid) begin
            r_sel_idx   <= n_sel_idx;
            r_sel_len   <= r_snap_len[n_sel_idx];
            r_sel_start <= r_snap_start[n_sel_idx];
        end
        if (out_ready && r_sel_valid) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
`default_nettype wire

/* design/six_frame_longest_orf_tracker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// six_frame_longest_orf_tracker
// Tracks the longest open reading frame over three plus and three minus
// frames from a stream of codon events and reports it at sequence end.
//
// Input channel: one codon event word per valid/ready handshake. The word is
// registered, then updates the per-frame state when it leaves the register,
// so a new word is taken every cycle unless a last word waits there. A word
// marked last additionally produces one result word; all frame state is
// cleared in the same update. Output channel: one result word per sequence,
// formed as the last word leaves the input register, through the snapshot,
// frame selection and coordinate register stages. Throughput is one word per
// cycle. A stalled receiver only holds back the result pipeline; codon words
// keep flowing until a last word finds the snapshot stage full, then the
// input waits. Reset clears all frame state, the pipeline and
// alt_start_enable, which is written through i_cfg_we/i_cfg_wdata; the user
// must write it only while idle, the block does not enforce this.
// ----------------------------------------------------------------------------
module six_frame_longest_orf_tracker (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_we,
    input  wire                    i_cfg_wdata,
    input  wire                    i_in_valid,
    output logic                   o_in_ready,
    input  sflot_pkg::t_in_word    i_in_word,
    output logic                   o_out_valid,
    input  wire                    i_out_ready,
    output sflot_pkg::t_out_word   o_out_word
);
    import sflot_pkg::*;

    logic     r_alt_en;
    logic     r_in_valid;
    t_in_word r_in;

    logic [NPLUS-1:0] r_in_orf, u_in_orf, n_in_orf;
    logic [NPLUS-1:0] r_stop_seen, u_stop_seen, n_stop_seen;
    t_len [NPLUS-1:0] r_cur_len, u_cur_len, n_cur_len;
    t_len [NPLUS-1:0] r_lss, u_lss, n_lss;
    t_pos_vec r_cur_start, u_cur_start, n_cur_start;
    t_len_vec r_best_len, u_best_len, n_best_len;
    t_pos_vec r_best_start, u_best_start, n_best_start;

    logic in_fire, snap_ready, is_start, is_stop;
    t_pos st;
    t_len lss_inc;

    assign in_fire    = r_in_valid && (!r_in.last_of_sequence || snap_ready);
    assign o_in_ready = !r_in_valid || in_fire;

    assign is_start = r_in.atg_start || (r_in.alt_start && r_alt_en);
    assign is_stop  = r_in.orf_stop;
    assign st       = r_in.position - POS_W'(r_in.frame);

    always_comb begin
        u_in_orf     = r_in_orf;
        u_stop_seen  = r_stop_seen;
        u_cur_len    = r_cur_len;
        u_lss        = r_lss;
        u_cur_start  = r_cur_start;
        u_best_len   = r_best_len;
        u_best_start = r_best_start;
        lss_inc      = '0;
        if (in_fire && r_in.frame != FRAME_NONE) begin
            for (int f = 0; f < NPLUS; f++) begin
                if (r_in.frame == FRAME_W'(f)) begin
                    if (!r_in.strand_minus) begin
                        if (r_in_orf[f]) begin
                            if (is_stop) begin
                                u_in_orf[f] = 1'b0;
                                if (r_cur_len[f] > r_best_len[f]) begin
                                    u_best_len[f]   = r_cur_len[f];
                                    u_best_start[f] = r_cur_start[f];
                                end
                            end else begin
                                u_cur_len[f] = sat_inc(r_cur_len[f]);
                            end
                        end else if (is_start) begin
                            u_in_orf[f]    = 1'b1;
                            u_cur_len[f]   = t_len'(1);
                            u_cur_start[f] = st;
                        end
                    end else begin
                        // minus frames count codons back to the last stop
                        if (is_stop) begin
                            u_stop_seen[f]         = 1'b1;
                            u_lss[f]               = '0;
                            u_cur_start[f + NPLUS] = st;
                        end else begin
                            lss_inc  = sat_inc(r_lss[f]);
                            u_lss[f] = lss_inc;
                            if (is_start && r_stop_seen[f]
                                    && lss_inc > r_best_len[f + NPLUS]) begin
                                u_best_len[f + NPLUS]   = lss_inc;
                                u_best_start[f + NPLUS] = r_cur_start[f + NPLUS];
                            end
                        end
                    end
                end
            end
        end
    end

    // the last word reports the updated bests and starts a fresh sequence
    always_comb begin
        if (in_fire && r_in.last_of_sequence) begin
            n_in_orf     = '0;
            n_stop_seen  = '0;
            n_cur_len    = '0;
            n_lss        = '0;
            n_cur_start  = '0;
            n_best_len   = '0;
            n_best_start = '0;
        end else begin
            n_in_orf     = u_in_orf;
            n_stop_seen  = u_stop_seen;
            n_cur_len    = u_cur_len;
            n_lss        = u_lss;
            n_cur_start  = u_cur_start;
            n_best_len   = u_best_len;
            n_best_start = u_best_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alt_en     <= 1'b0;
            r_in_valid   <= 1'b0;
            r_in_orf     <= '0;
            r_stop_seen  <= '0;
            r_cur_len    <= '0;
            r_lss        <= '0;
            r_cur_start  <= '0;
            r_best_len   <= '0;
            r_best_start <= '0;
        end else begin
            if (i_cfg_we) begin
                r_alt_en <= i_cfg_wdata;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            r_in_orf     <= n_in_orf;
            r_stop_seen  <= n_stop_seen;
            r_cur_len    <= n_cur_len;
            r_lss        <= n_lss;
            r_cur_start  <= n_cur_start;
            r_best_len   <= n_best_len;
            r_best_start <= n_best_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_word;
        end
    end

    sflot_result u_result (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_snap_valid (r_in_valid && r_in.last_of_sequence),
        .o_snap_ready (snap_ready),
        .i_best_len   (u_best_len),
        .i_best_start (u_best_start),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_word   (o_out_word)
    );

endmodule
`default_nettype wire

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the six-frame longest ORF tracker. Codon words are
// sent in bursts as whole sequences, each closed by a last word. A scoreboard
// keeps its own copy of the frame state and predicts the one report per
// sequence. Every report from the block is compared field by field against
// the oldest prediction. The alternative start setting is toggled between
// phases while the block is idle. The receiver stalls on its own pattern and
// once holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_top;
    import sflot_pkg::*;

    class orf_scoreboard;
        bit        alt_en;
        bit        in_orf [3];
        t_len      run_len [NFRAMES];
        t_len      since_stop [NPLUS];
        bit        stop_seen [NPLUS];
        t_pos      run_start [NFRAMES];
        t_len      best_len [NFRAMES];
        t_pos      best_start [NFRAMES];
        t_out_word orf_reports_q [$];
        int unsigned n_words;
        int unsigned n_reports;
        int unsigned n_errors;

        function void clear_frames();
            for (int i = 0; i < NFRAMES; i++) begin
                run_len[i]    = '0;
                run_start[i]  = '0;
                best_len[i]   = '0;
                best_start[i] = '0;
            end
            for (int i = 0; i < NPLUS; i++) begin
                in_orf[i]     = 1'b0;
                since_stop[i] = '0;
                stop_seen[i]  = 1'b0;
            end
        endfunction

        function t_len bump(t_len v);
            return (v == LEN_MAX) ? v : v + t_len'(1);
        endfunction

        function int unsigned pending();
            return orf_reports_q.size();
        endfunction

        // note one accepted codon word; a last word yields one report
        function void track_codon(t_in_word w);
            int unsigned k;
            int unsigned top;
            bit          opens;
            t_pos        st;
            t_out_word   r;
            logic [31:0] to_sum;
            n_words++;
            opens = w.atg_start || (w.alt_start && alt_en);
            if (w.frame != FRAME_NONE) begin
                k  = 32'(w.frame);
                st = w.position - t_pos'(w.frame);
                if (!w.strand_minus) begin
                    if (in_orf[k]) begin
                        if (w.orf_stop) begin
                            in_orf[k] = 1'b0;
                            if (run_len[k] > best_len[k]) begin
                                best_len[k]   = run_len[k];
                                best_start[k] = run_start[k];
                            end
                        end else begin
                            run_len[k] = bump(run_len[k]);
                        end
                    end else if (opens) begin
                        in_orf[k]    = 1'b1;
                        run_len[k]   = t_len'(1);
                        run_start[k] = st;
                    end
                end else if (w.orf_stop) begin
                    stop_seen[k]      = 1'b1;
                    run_len[k+3]      = '0;
                    since_stop[k]     = '0;
                    run_start[k+3]    = st;
                end else begin
                    since_stop[k] = bump(since_stop[k]);
                    // minus frames only count once a stop has been seen
                    if (opens && stop_seen[k]) begin
                        run_len[k+3] = since_stop[k];
                        if (run_len[k+3] > best_len[k+3]) begin
                            best_len[k+3]   = run_len[k+3];
                            best_start[k+3] = run_start[k+3];
                        end
                    end
                end
            end
            if (w.last_of_sequence) begin
                top = 0;
                for (int i = 1; i < NFRAMES; i++) begin
                    if (best_len[i] > best_len[top]) begin
                        top = i;
                    end
                end
                r.best_frame   = IDX_W'(top);
                r.best_length  = best_len[top];
                r.orf_from     = best_start[top] + t_pos'(top % NPLUS);
                to_sum         = 32'(r.orf_from) + 32'(best_len[top]) * 3 + 32'd2;
                r.orf_to       = (to_sum > 32'(TO_MAX)) ? TO_MAX : to_sum[TO_W-1:0];
                r.orf_on_minus = (top >= NPLUS);
                orf_reports_q.push_back(r);
                clear_frames();
            end
        endfunction

        function bit field_matches(string what, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: error on %s, expected 0x%0h, actual 0x%0h", $time, what,
                         want, got);
                n_errors++;
                return 1'b0;
            end
            return 1'b1;
        endfunction

        function void check_result(t_out_word got);
            t_out_word want;
            if (orf_reports_q.size() == 0) begin
                $display("%0t: error, report with none pending, expected none, actual 0x%0h",
                         $time, got);
                n_errors++;
                return;
            end
            want = orf_reports_q.pop_front();
            n_reports++;
            void'(field_matches("best_frame", 32'(want.best_frame), 32'(got.best_frame)));
            void'(field_matches("best_length", 32'(want.best_length),
                                32'(got.best_length)));
            void'(field_matches("orf_from", 32'(want.orf_from), 32'(got.orf_from)));
            void'(field_matches("orf_to", 32'(want.orf_to), 32'(got.orf_to)));
            void'(field_matches("orf_on_minus", 32'(want.orf_on_minus),
                                32'(got.orf_on_minus)));
        endfunction
    endclass

    localparam int CLK_HALF   = 6;
    localparam int TIMEOUT_T  = 12 * 400000;
    localparam int SETTLE_CYC = 10;
    localparam int HOLD_CYC   = 90;
    localparam int PHASE_WORDS = 230;

    logic      i_clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cfg_we = 1'b0;
    logic      cfg_wdata = 1'b0;
    logic      in_valid = 1'b0;
    t_in_word  in_word = '0;
    logic      out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_word o_out_word;

    orf_scoreboard sb = new;

    int unsigned burst_left;
    int unsigned n_random;
    int unsigned n_cfg_writes;
    bit          steady;
    bit          hold_req;

    six_frame_longest_orf_tracker dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (o_out_word)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (rst_n && o_out_valid && out_ready) begin
            sb.check_result(o_out_word);
        end
    end

    // receiver: rotating stall patterns plus one long hold-off on request
    initial begin : rx_pattern
        int unsigned cyc;
        int unsigned hold_left;
        bit [7:0]    mask;
        cyc       = 0;
        hold_left = 0;
        mask      = 8'hA5;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc % 48 == 0) begin
                mask = 8'($urandom);
            end
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYC;
            end
            if (hold_left != 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else begin
                case ((cyc / 48) % 4)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    2: out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= mask[cyc[2:0]];
                endcase
            end
        end
    end

    initial begin
        #TIMEOUT_T;
        $display("Mismatches found");
        $finish;
    end

    function automatic t_in_word codon(t_pos p, logic [1:0] f, bit m, bit a, bit alt,
                                       bit s, bit l);
        t_in_word w;
        w.position         = p;
        w.frame            = f;
        w.strand_minus     = m;
        w.atg_start        = a;
        w.alt_start        = alt;
        w.orf_stop         = s;
        w.last_of_sequence = l;
        return w;
    endfunction

    // valid stays high between back-to-back words, dropped only for a gap
    task automatic push_word(input t_in_word w);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = steady ? 0 : $urandom_range(0, 6);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        sb.track_codon(w);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic cfg_write(input bit v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        sb.alt_en = v;
        n_cfg_writes++;
        @(posedge i_clk);
    endtask

    // clean sequences walk consecutive positions, noisy ones jump anywhere
    task automatic send_sequence(input int unsigned n_codons, input bit noisy);
        t_in_word w;
        t_pos     pos;
        pos = t_pos'($urandom);
        for (int unsigned i = 0; i < n_codons; i++) begin
            if (noisy) begin
                w.position = t_pos'($urandom);
                w.frame    = FRAME_W'($urandom_range(0, 3));
            end else begin
                w.position = pos;
                w.frame    = FRAME_W'(pos % 3);
                pos        = pos + t_pos'(1);
            end
            w.strand_minus     = 1'($urandom_range(0, 1));
            w.atg_start        = ($urandom_range(0, 99) < 14);
            w.alt_start        = ($urandom_range(0, 99) < 14);
            w.orf_stop         = ($urandom_range(0, 99) < 10);
            w.last_of_sequence = (i == n_codons - 1);
            push_word(w);
            n_random++;
        end
    endtask

    task automatic send_random_sequence();
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick < 14) begin
            send_sequence($urandom_range(3, 40), 1'b0);
        end else if (pick < 19) begin
            send_sequence($urandom_range(1, 10), 1'b1);
        end else begin
            send_sequence($urandom_range(80, 160), 1'b0);
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        cfg_write(1'b0);
        // empty sequence, then a frame-three word that only closes the sequence
        push_word(codon(24'h000000, 2'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
        push_word(codon(24'h000005, FRAME_NONE, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1));
        // plus ORF wrapping at position zero, ties with a minus ORF
        push_word(codon(24'hFFFFFF, 2'd2, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
        push_word(codon(24'h000003, 2'd2, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        push_word(codon(24'h000006, 2'd2, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
        push_word(codon(24'h000000, 2'd1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
        push_word(codon(24'h00000A, 2'd1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0));
        push_word(codon(24'h00000D, 2'd1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        push_word(codon(24'h000010, 2'd1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
        push_word(codon(24'h000014, 2'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
        push_word(codon(24'h000002, 2'd1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0));
        push_word(codon(24'h00001E, 2'd0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1));
        drain();

        cfg_write(1'b1);
        // alternative starts open ORFs on both strands
        push_word(codon(24'h000028, 2'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
        push_word(codon(24'h00002B, 2'd0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
        push_word(codon(24'h00002E, 2'd0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0));
        push_word(codon(24'h000032, 2'd2, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0));
        push_word(codon(24'h000035, 2'd2, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0));
        push_word(codon(24'h000038, 2'd2, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        push_word(codon(24'h00003B, 2'd2, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0));
        push_word(codon(24'hFFFFFF, 2'd0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1));
        drain();

        for (int p = 0; p < 5; p++) begin
            cfg_write(p % 2 == 0);
            if (p == 0) begin
                // short sequences back to back against a stalled receiver
                hold_req = 1'b1;
                steady   = 1'b1;
                repeat (16) send_sequence($urandom_range(1, 3), 1'b0);
                steady = 1'b0;
            end
            while (n_random < (p + 1) * PHASE_WORDS) send_random_sequence();
            drain();
        end

        repeat (SETTLE_CYC) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $display("%0t: error, %0d reports never arrived", $time, sb.pending());
            sb.n_errors += sb.pending();
        end
        $display("run covered %0d codon words, %0d of them random, and %0d reports",
                 sb.n_words, n_random, sb.n_reports);
        $display("alternative start setting written %0d times, long receiver hold-off once",
                 n_cfg_writes);
        if (sb.n_errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
